@@ hw/rtl/bps_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and the per-axis clamp function of the bilinear pixel sampler.
package bps_pkg;

	localparam int COORD_W   = 18;  // signed Q.8 coordinate
	localparam int FRAC_W    = 8;   // fraction bits of a coordinate
	localparam int DIM_W     = 9;   // width, height, pitch, neighbor index
	localparam int WGT_W     = 9;   // one-axis weight, 0..256
	localparam int PROD_W    = 17;  // two-axis weight, 0..65536
	localparam int BASE_W    = 20;  // pitch*row + column + pitch + 1
	localparam int IDX_W     = 16;  // write address field
	localparam int COL_W     = 24;  // packed RGB
	localparam int CH_W      = 8;
	localparam int ACC_W     = 24;  // channel accumulator
	localparam int CFG_AW    = 2;
	localparam int CMD_DEPTH = 4;
	localparam int OUT_DEPTH = 4;
	localparam int OCC_W     = $clog2(OUT_DEPTH + 1);

	localparam logic [WGT_W-1:0] ONE   = WGT_W'(256);
	localparam logic [ACC_W-1:0] ROUND = ACC_W'(32768);
	localparam logic [CH_W-1:0]  ALPHA = 8'hFF;

	typedef enum logic [CFG_AW-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_PITCH  = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		REQ_WRITE  = 1'b0,
		REQ_SAMPLE = 1'b1
	} req_t;

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [DIM_W-1:0] pitch;
	} cfg_t;

	typedef struct packed {
		logic [DIM_W-1:0] lo;
		logic [WGT_W-1:0] wlo;
		logic [WGT_W-1:0] whi;
	} axis_t;

	typedef struct packed {
		req_t              kind;
		logic [BASE_W-1:0] addr;    // write address or base of the 2x2 patch
		logic [COL_W-1:0]  colour;
		logic [PROD_W-1:0] w11;
		logic [PROD_W-1:0] w21;
		logic [PROD_W-1:0] w12;
		logic [PROD_W-1:0] w22;
	} cmd_t;

	localparam int CMD_W = $bits(cmd_t);

	// Clamp one axis: lower neighbor plus the weights of both neighbors.
	function automatic axis_t clamp_axis(input logic [COORD_W-1:0] raw,
	                                     input logic [DIM_W-1:0] size);
		logic [COORD_W-1:0] v;
		logic [DIM_W-1:0]   sz;
		logic [DIM_W-1:0]   ip;
		logic [FRAC_W-1:0]  fr;
		axis_t              a;
		v  = raw[COORD_W-1] ? '0 : raw;
		sz = (size < DIM_W'(2)) ? DIM_W'(2) : size;
		ip = v[FRAC_W +: DIM_W];
		fr = v[FRAC_W-1:0];
		if (({1'b0, ip} + (DIM_W+1)'(1)) >= {1'b0, sz}) begin
			a.lo  = sz - DIM_W'(2);
			a.wlo = '0;
			a.whi = ONE;
		end else begin
			a.lo  = ip;
			a.wlo = ONE - {1'b0, fr};
			a.whi = {1'b0, fr};
		end
		return a;
	endfunction

endpackage

@@ hw/rtl/bilinear_pixel_sampler.sv @@
`timescale 1ns / 1ps
// Top level of the bilinear pixel sampler: config registers, front, command queue, back.
//
// Usage:
//   Input channel is a queue push side: a transaction is taken when push is high and
//   full is low. req_type 0 writes store_colour to frame word store_index (mod
//   STORE_WORDS, a power of two); req_type 1 samples at (sample_x, sample_y), Q.8.
//   Result channel is a queue pop side: while empty is low, sample_colour holds the
//   oldest result; it is taken when pop is high. Writes give no result.
//   Config: cfg_we writes cfg_data into register cfg_addr (0 width, 1 height, 2 pitch)
//   in the same edge; only while no transaction is in flight.
// Timing:
//   With idle queues a sample goes through two front stages, the command queue, four
//   frame reads and the result FIFO to the pop side. The single frame memory port
//   sets the rate: a sample holds it for four neighbor reads, during which no new
//   command starts; a pixel write takes one access. Front accepts one transaction
//   per cycle while full is low into a 4-deep command queue, absorbing bursts.
// Reset:
//   arst_n clears all queues and control; registers go to 256. Frame memory is not
//   cleared: reading a never-written pixel gives undefined color.
// Stall:
//   A held-off pop fills the 4-entry result FIFO; the back end then stops starting
//   samples, the command queue fills and full rises. No transaction is lost.
module bilinear_pixel_sampler #(
	parameter int STORE_WORDS = 65536
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic                               req_type,
	input  logic [bps_pkg::IDX_W-1:0]          store_index,
	input  logic [bps_pkg::COL_W-1:0]          store_colour,
	input  logic signed [bps_pkg::COORD_W-1:0] sample_x,
	input  logic signed [bps_pkg::COORD_W-1:0] sample_y,
	output logic                               empty,
	input  logic                               pop,
	output logic [31:0]                        sample_colour,
	input  logic                               cfg_we,
	input  logic [bps_pkg::CFG_AW-1:0]         cfg_addr,
	input  logic [bps_pkg::DIM_W-1:0]          cfg_data
);
	import bps_pkg::*;

	cfg_t             cfg_q;
	logic             cmd_push;
	cmd_t             cmd_in;
	logic             cmd_full;
	logic             cmd_empty;
	logic             cmd_pop;
	logic [CMD_W-1:0] cmd_out_bits;
	cmd_t             cmd_out;
	logic [COL_W-1:0] res_colour;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= DIM_W'(256);
			cfg_q.height <= DIM_W'(256);
			cfg_q.pitch  <= DIM_W'(256);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_WIDTH:  cfg_q.width  <= cfg_data;
				REG_HEIGHT: cfg_q.height <= cfg_data;
				REG_PITCH:  cfg_q.pitch  <= cfg_data;
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	// accept + clamp + address/weight math
	bps_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.push         (push),
		.full         (full),
		.req_type     (req_type),
		.store_index  (store_index),
		.store_colour (store_colour),
		.sample_x     (sample_x),
		.sample_y     (sample_y),
		.cmd_push     (cmd_push),
		.cmd          (cmd_in),
		.cmd_full     (cmd_full)
	);

	// decouples front from the memory-bound back end; keeps write/sample order
	bps_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd_in),
		.pop    (cmd_pop),
		.full   (cmd_full),
		.empty  (cmd_empty),
		.dout   (cmd_out_bits)
	);

	assign cmd_out = cmd_t'(cmd_out_bits);

	bps_back #(
		.STORE_WORDS (STORE_WORDS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pitch      (cfg_q.pitch),
		.cmd_empty  (cmd_empty),
		.cmd        (cmd_out),
		.cmd_pop    (cmd_pop),
		.res_empty  (empty),
		.res_pop    (pop),
		.res_colour (res_colour)
	);

	// alpha is constant opaque
	assign sample_colour = {ALPHA, res_colour};

`ifndef SYNTH
	a_cmd_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !cmd_full)
		else $error("command queue overflow");
	a_cmd_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty)
		else $error("command popped from empty queue");
	a_cfg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_we |=> cfg_q == $past(cfg_q))
		else $error("config changed without a write");
`endif
endmodule

@@ hw/rtl/bps_ram.sv @@
`timescale 1ns / 1ps
// Generic single-port synchronous RAM with registered read data.
module bps_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

@@ hw/rtl/bps_fifo.sv @@
`timescale 1ns / 1ps
// Small register FIFO used between the sampler stages and at the result port.
module bps_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic             full,
	output logic             empty,
	output logic [WIDTH-1:0] dout
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fifo count exceeds depth");
	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full && !do_pop |=> count_q == $past(count_q))
		else $error("fifo count moved while full and idle on read side");
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> !empty)
		else $error("fifo empty after a push");
`endif
endmodule

@@ hw/rtl/bps_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts transactions, clamps coordinates, forms patch base and weights.
module bps_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bps_pkg::cfg_t                   cfg,
	input  logic                            push,
	output logic                            full,
	input  logic                            req_type,
	input  logic [bps_pkg::IDX_W-1:0]       store_index,
	input  logic [bps_pkg::COL_W-1:0]       store_colour,
	input  logic signed [bps_pkg::COORD_W-1:0] sample_x,
	input  logic signed [bps_pkg::COORD_W-1:0] sample_y,
	output logic                            cmd_push,
	output bps_pkg::cmd_t                   cmd,
	input  logic                            cmd_full
);
	import bps_pkg::*;

	logic              v_s1;
	req_t              kind_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [COL_W-1:0]  col_s1;
	axis_t             ax_s1;
	axis_t             ay_s1;
	logic              v_s2;
	cmd_t              cmd_s2;
	logic              adv1;
	logic              adv2;
	logic              accept;
	logic [2*DIM_W-1:0] row_off;
	logic [2*WGT_W-1:0] m11, m21, m12, m22;
	cmd_t              cmd_d;

	assign adv2     = !v_s2 || !cmd_full;
	assign adv1     = !v_s1 || adv2;
	assign full     = !adv1;
	assign accept   = push && adv1;
	assign cmd_push = v_s2 && !cmd_full;
	assign cmd      = cmd_s2;

	// stage 2 math: one row multiply plus column add, four weight products
	always_comb begin
		row_off      = cfg.pitch * ay_s1.lo;
		m11          = ax_s1.wlo * ay_s1.wlo;
		m21          = ax_s1.whi * ay_s1.wlo;
		m12          = ax_s1.wlo * ay_s1.whi;
		m22          = ax_s1.whi * ay_s1.whi;
		cmd_d.kind   = kind_s1;
		cmd_d.colour = col_s1;
		cmd_d.w11    = PROD_W'(m11);
		cmd_d.w21    = PROD_W'(m21);
		cmd_d.w12    = PROD_W'(m12);
		cmd_d.w22    = PROD_W'(m22);
		if (kind_s1 == REQ_WRITE) begin
			cmd_d.addr = BASE_W'(idx_s1);
		end else begin
			cmd_d.addr = BASE_W'(row_off) + BASE_W'(ax_s1.lo);
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			kind_s1 <= req_t'(req_type);
			idx_s1  <= store_index;
			col_s1  <= store_colour;
			ax_s1   <= clamp_axis($unsigned(sample_x), cfg.width);
			ay_s1   <= clamp_axis($unsigned(sample_y), cfg.height);
		end
		if (adv2) begin
			cmd_s2 <= cmd_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= accept;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

`ifndef SYNTH
	a_hold_s2: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && cmd_full |=> v_s2 && cmd_s2 == $past(cmd_s2))
		else $error("front stage 2 lost its command under stall");
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv2 |=> v_s1)
		else $error("front stage 1 dropped while stage 2 stalled");
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> v_s1 && v_s2 && cmd_full)
		else $error("front reports full without a stalled pipeline");
`endif
endmodule

@@ hw/rtl/bps_back.sv @@
`timescale 1ns / 1ps
// Back end: frame memory, four-read patch fetch, per-channel MAC and result FIFO.
module bps_back #(
	parameter int STORE_WORDS = 65536
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [bps_pkg::DIM_W-1:0] pitch,
	input  logic                      cmd_empty,
	input  bps_pkg::cmd_t             cmd,
	output logic                      cmd_pop,
	output logic                      res_empty,
	input  logic                      res_pop,
	output logic [bps_pkg::COL_W-1:0] res_colour
);
	import bps_pkg::*;

	localparam int AW = $clog2(STORE_WORDS);

	logic              busy_q;
	logic [1:0]        step_q;
	cmd_t              cur_q;
	logic [OCC_W-1:0]  occ_q;
	logic              can_start;
	logic              start_rd;
	logic              start_wr;
	logic [1:0]        rd_step;
	logic [BASE_W-1:0] src_addr;
	logic [BASE_W-1:0] offset;
	logic [BASE_W-1:0] addr_sum;
	logic [PROD_W-1:0] weight;
	logic              ram_we;
	logic [AW-1:0]     ram_addr;
	logic [COL_W-1:0]  ram_rdata;
	logic              rd_v_s1;
	logic              rd_first_s1;
	logic              rd_last_s1;
	logic [PROD_W-1:0] rd_w_s1;
	logic [ACC_W-1:0]  acc_q   [3];
	logic [ACC_W-1:0]  acc_nxt [3];
	logic [PROD_W+CH_W-1:0] mac_prod [3];
	logic              out_push;
	logic              out_full;
	logic [COL_W-1:0]  out_din;
	logic              res_take;

	assign can_start = !busy_q && !cmd_empty
	                   && (cmd.kind == REQ_WRITE || occ_q < OCC_W'(OUT_DEPTH));
	assign cmd_pop   = can_start;
	assign start_rd  = can_start && cmd.kind == REQ_SAMPLE;
	assign start_wr  = can_start && cmd.kind == REQ_WRITE;
	assign res_take  = res_pop && !res_empty;

	// read order: base, base+1, base+pitch, base+pitch+1
	always_comb begin
		rd_step  = busy_q ? step_q : 2'd0;
		src_addr = busy_q ? cur_q.addr : cmd.addr;
		case (rd_step)
			2'd0: begin
				offset = '0;
				weight = busy_q ? cur_q.w11 : cmd.w11;
			end
			2'd1: begin
				offset = BASE_W'(1);
				weight = cur_q.w21;
			end
			2'd2: begin
				offset = BASE_W'(pitch);
				weight = cur_q.w12;
			end
			default: begin
				offset = BASE_W'(pitch) + BASE_W'(1);
				weight = cur_q.w22;
			end
		endcase
		addr_sum = src_addr + offset;
		ram_we   = start_wr;
		ram_addr = start_wr ? cmd.addr[AW-1:0] : addr_sum[AW-1:0];
	end

	bps_ram #(
		.WIDTH (COL_W),
		.DEPTH (STORE_WORDS)
	) u_frame (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (cmd.colour),
		.rdata (ram_rdata)
	);

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			mac_prod[c] = rd_w_s1 * ram_rdata[c*CH_W +: CH_W];
			acc_nxt[c]  = (rd_first_s1 ? ROUND : acc_q[c]) + ACC_W'(mac_prod[c]);
		end
		out_din  = {acc_nxt[2][ACC_W-1 -: CH_W], acc_nxt[1][ACC_W-1 -: CH_W],
		            acc_nxt[0][ACC_W-1 -: CH_W]};
		out_push = rd_v_s1 && rd_last_s1;
	end

	always_ff @(posedge clk) begin
		if (start_rd) begin
			cur_q <= cmd;
		end
		rd_w_s1     <= weight;
		rd_first_s1 <= start_rd;
		rd_last_s1  <= busy_q && step_q == 2'd3;
		if (rd_v_s1) begin
			for (int c = 0; c < 3; c++) begin
				acc_q[c] <= acc_nxt[c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			step_q  <= 2'd0;
			rd_v_s1 <= 1'b0;
			occ_q   <= '0;
		end else begin
			rd_v_s1 <= start_rd || busy_q;
			if (start_rd) begin
				busy_q <= 1'b1;
				step_q <= 2'd1;
			end else if (busy_q) begin
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
					step_q <= 2'd0;
				end else begin
					step_q <= step_q + 2'd1;
				end
			end
			case ({start_rd, res_take})
				2'b10:   occ_q <= occ_q + OCC_W'(1);
				2'b01:   occ_q <= occ_q - OCC_W'(1);
				default: occ_q <= occ_q;
			endcase
		end
	end

	bps_fifo #(
		.WIDTH (COL_W),
		.DEPTH (OUT_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.din    (out_din),
		.pop    (res_pop),
		.full   (out_full),
		.empty  (res_empty),
		.dout   (res_colour)
	);

`ifndef SYNTH
	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("result pushed into a full FIFO");
	a_port_free: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !busy_q)
		else $error("frame write collided with a patch fetch");
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(OUT_DEPTH))
		else $error("result credit count out of range");
	a_fetch_len: assert property (@(posedge clk) disable iff (!arst_n)
		start_rd |=> busy_q ##1 busy_q ##1 busy_q ##1 !busy_q)
		else $error("patch fetch not four reads long");
`endif
endmodule
